[hw/rtl/nfa_pkg.sv]
// Shared types, widths, codes and reset values of the NOR flash array model.
// No dependencies; every other file of the block but nfa_ram imports this package.
package nfa_pkg;

	localparam int unsigned CAPACITY_DEFAULT = 65536;

	localparam int ADDR_BITS       = 16;
	localparam int DATA_BITS       = 8;
	localparam int COUNT_BITS      = 16;
	localparam int CMD_BITS        = 2;
	localparam int STATUS_BITS     = 2;
	localparam int CFG_INDEX_BITS  = 2;
	localparam int CFG_DATA_BITS   = 17;
	localparam int PAGE_BYTES_BITS = 13;
	localparam int PAGE_COUNT_BITS = 17;
	localparam int PROG_UNIT_BITS  = 9;
	localparam int ERASE_UNIT_BITS = 13;
	localparam int PROD_BITS       = PAGE_BYTES_BITS + PAGE_COUNT_BITS;
	localparam int LEN_BITS        = COUNT_BITS + ERASE_UNIT_BITS;
	localparam int SUM_BITS        = LEN_BITS + 1;

	localparam logic [DATA_BITS-1:0] ERASED_BYTE = 8'hFF;

	localparam logic [PAGE_BYTES_BITS-1:0] PAGE_BYTES_RESET = 13'd256;
	localparam logic [PAGE_COUNT_BITS-1:0] PAGE_COUNT_RESET = 17'd256;
	localparam logic [PROG_UNIT_BITS-1:0]  PROG_UNIT_RESET  = 9'd1;
	localparam logic [ERASE_UNIT_BITS-1:0] ERASE_UNIT_RESET = 13'd4096;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_READ    = 2'd0,
		CMD_PROGRAM = 2'd1,
		CMD_ERASE   = 2'd2
	} command_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK         = 2'd0,
		ST_MISALIGNED = 2'd1,
		ST_RANGE      = 2'd2
	} status_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PAGE_BYTES = 2'd0,
		REG_PAGE_COUNT = 2'd1,
		REG_PROG_UNIT  = 2'd2,
		REG_ERASE_UNIT = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CALC,
		S_EVAL,
		S_READ,
		S_MODIFY,
		S_ERASE,
		S_DONE
	} state_t;

	typedef struct packed {
		logic clear_step;
		logic load_item;
		logic calc;
		logic eval;
		logic modify;
		logic erase_step;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic refused;
		logic is_erase;
		logic erase_done;
		logic out_free;
	} dp_status_t;

endpackage

[hw/rtl/nfa_intf.sv]
// Command and response channel interfaces of the NOR flash array model.
// Depends on nfa_pkg for field widths.
interface nfa_cmd_if;
	import nfa_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CMD_BITS-1:0]   command;
	logic [ADDR_BITS-1:0]  byte_address;
	logic [DATA_BITS-1:0]  write_data;
	logic                  burst_start;
	logic [COUNT_BITS-1:0] erase_count;

	modport source (output valid, command, byte_address, write_data, burst_start, erase_count,
		input ready);
	modport sink (input valid, command, byte_address, write_data, burst_start, erase_count,
		output ready);
endinterface

interface nfa_rsp_if;
	import nfa_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [DATA_BITS-1:0]   read_data;
	logic [STATUS_BITS-1:0] status;

	modport source (output valid, read_data, status, input ready);
	modport sink (input valid, read_data, status, output ready);
endinterface

[hw/rtl/nfa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nfa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hw/rtl/nfa_ctrl.sv]
// Controller state machine of the NOR flash array model.
// Depends on nfa_pkg for the state, command and status types.
module nfa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  nfa_pkg::dp_status_t sts,
	output nfa_pkg::dp_cmd_t    ctl
);
	import nfa_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (cmd_valid) state_d = S_CALC;
			end
			S_CALC: state_d = S_EVAL;
			S_EVAL: begin
				if (sts.refused) state_d = S_DONE;
				else if (sts.is_erase) state_d = S_ERASE;
				else state_d = S_READ;
			end
			S_READ: state_d = S_MODIFY;
			S_MODIFY: state_d = S_DONE;
			S_ERASE: begin
				if (sts.erase_done) state_d = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd_ready      = (state_q == S_IDLE);
		ctl.clear_step = (state_q == S_CLEAR);
		ctl.load_item  = (state_q == S_IDLE) && cmd_valid;
		ctl.calc       = (state_q == S_CALC);
		ctl.eval       = (state_q == S_EVAL);
		ctl.modify     = (state_q == S_MODIFY);
		ctl.erase_step = (state_q == S_ERASE) && !sts.erase_done;
		ctl.load_out   = (state_q == S_DONE) && sts.out_free;
	end
endmodule

[hw/rtl/nfa_dp.sv]
// Datapath of the NOR flash array model: configuration, checks, cell array,
// erase cursor and output register. Depends on nfa_pkg and nfa_ram.
module nfa_dp #(
	parameter int unsigned CAPACITY_BYTES = nfa_pkg::CAPACITY_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write_en,
	input  logic [nfa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [nfa_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic [nfa_pkg::CMD_BITS-1:0]       command,
	input  logic [nfa_pkg::ADDR_BITS-1:0]      byte_address,
	input  logic [nfa_pkg::DATA_BITS-1:0]      write_data,
	input  logic                               burst_start,
	input  logic [nfa_pkg::COUNT_BITS-1:0]     erase_count,
	input  nfa_pkg::dp_cmd_t                   ctl,
	output nfa_pkg::dp_status_t                sts,
	input  logic                               rsp_ready,
	output logic                               rsp_valid,
	output logic [nfa_pkg::DATA_BITS-1:0]      read_data,
	output logic [nfa_pkg::STATUS_BITS-1:0]    status
);
	import nfa_pkg::*;

	localparam int MEM_AW    = $clog2(CAPACITY_BYTES);
	localparam int SIZE_BITS = $clog2(CAPACITY_BYTES + 1);

	logic [PAGE_BYTES_BITS-1:0] page_bytes_q;
	logic [PAGE_COUNT_BITS-1:0] page_count_q;
	logic [PROG_UNIT_BITS-1:0]  prog_unit_q;
	logic [ERASE_UNIT_BITS-1:0] erase_unit_q;

	logic [CMD_BITS-1:0]   cmd_q;
	logic [ADDR_BITS-1:0]  addr_q;
	logic [DATA_BITS-1:0]  data_q;
	logic                  start_q;
	logic [COUNT_BITS-1:0] count_q;

	logic [SIZE_BITS-1:0] size_q;
	logic [LEN_BITS-1:0]  len_q;
	logic [PROD_BITS-1:0] geom_prod;

	logic [ADDR_BITS-1:0] cursor_q;
	logic [LEN_BITS-1:0]  remaining_q;
	logic [MEM_AW-1:0]    clear_addr_q;

	logic [DATA_BITS-1:0] rd_q;
	status_t              st_q;
	status_t              eval_status;

	logic                 out_valid_q;
	logic [DATA_BITS-1:0] out_data_q;
	status_t              out_status_q;

	logic [ADDR_BITS-1:0] prog_mask;
	logic [ADDR_BITS-1:0] erase_mask;
	logic                 rw_range;
	logic                 erase_range;
	logic                 cursor_in_cap;
	logic                 is_program;
	logic [DATA_BITS-1:0] mod_value;

	logic                 mem_we;
	logic [MEM_AW-1:0]    mem_waddr;
	logic [DATA_BITS-1:0] mem_wdata;
	logic [DATA_BITS-1:0] mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_bytes_q <= PAGE_BYTES_RESET;
			page_count_q <= PAGE_COUNT_RESET;
			prog_unit_q  <= PROG_UNIT_RESET;
			erase_unit_q <= ERASE_UNIT_RESET;
		end else if (cfg_write_en) begin
			unique case (reg_index_t'(cfg_index))
				REG_PAGE_BYTES: page_bytes_q <= cfg_data[PAGE_BYTES_BITS-1:0];
				REG_PAGE_COUNT: page_count_q <= cfg_data[PAGE_COUNT_BITS-1:0];
				REG_PROG_UNIT:  prog_unit_q  <= cfg_data[PROG_UNIT_BITS-1:0];
				REG_ERASE_UNIT: erase_unit_q <= cfg_data[ERASE_UNIT_BITS-1:0];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			cmd_q   <= command;
			addr_q  <= byte_address;
			data_q  <= write_data;
			start_q <= burst_start;
			count_q <= erase_count;
		end
	end

	assign geom_prod = PROD_BITS'(page_bytes_q) * PROD_BITS'(page_count_q);

	always_ff @(posedge clk) begin
		if (ctl.calc) begin
			size_q <= (geom_prod > PROD_BITS'(CAPACITY_BYTES)) ?
				SIZE_BITS'(CAPACITY_BYTES) : SIZE_BITS'(geom_prod);
			len_q  <= LEN_BITS'(count_q) * LEN_BITS'(erase_unit_q);
		end
	end

	assign prog_mask   = ADDR_BITS'(prog_unit_q) - ADDR_BITS'(1);
	assign erase_mask  = ADDR_BITS'(erase_unit_q) - ADDR_BITS'(1);
	assign rw_range    = SUM_BITS'(addr_q) >= SUM_BITS'(size_q);
	assign erase_range = (SUM_BITS'(addr_q) + SUM_BITS'(len_q)) > SUM_BITS'(size_q);

	always_comb begin
		case (cmd_q) inside
			CMD_READ, CMD_PROGRAM: begin
				if (rw_range) eval_status = ST_RANGE;
				else if (start_q && ((addr_q & prog_mask) != '0)) eval_status = ST_MISALIGNED;
				else eval_status = ST_OK;
			end
			CMD_ERASE: begin
				if (erase_range) eval_status = ST_RANGE;
				else if ((addr_q & erase_mask) != '0) eval_status = ST_MISALIGNED;
				else eval_status = ST_OK;
			end
			default: eval_status = ST_RANGE;
		endcase
	end

	assign is_program    = (cmd_q == CMD_PROGRAM);
	assign mod_value     = mem_rdata & (is_program ? data_q : ERASED_BYTE);
	assign cursor_in_cap = 32'(cursor_q) < 32'(CAPACITY_BYTES);

	always_ff @(posedge clk) begin
		if (ctl.eval) begin
			st_q        <= eval_status;
			rd_q        <= '0;
			cursor_q    <= addr_q;
			remaining_q <= len_q;
		end else if (ctl.modify) begin
			rd_q <= mod_value;
		end else if (ctl.erase_step) begin
			cursor_q    <= cursor_q + ADDR_BITS'(1);
			remaining_q <= remaining_q - LEN_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_addr_q <= '0;
		end else if (ctl.clear_step) begin
			clear_addr_q <= clear_addr_q + MEM_AW'(1);
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clear_addr_q;
		mem_wdata = ERASED_BYTE;
		if (ctl.clear_step) begin
			mem_we = 1'b1;
		end else if (ctl.erase_step) begin
			mem_we    = cursor_in_cap;
			mem_waddr = MEM_AW'(cursor_q);
		end else if (ctl.modify) begin
			mem_we    = is_program;
			mem_waddr = MEM_AW'(addr_q);
			mem_wdata = mod_value;
		end
	end

	nfa_ram #(
		.WIDTH(DATA_BITS),
		.DEPTH(CAPACITY_BYTES)
	) u_cells (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(MEM_AW'(addr_q)),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_data_q   <= rd_q;
			out_status_q <= st_q;
		end
	end

	assign sts.clear_last = (clear_addr_q == MEM_AW'(CAPACITY_BYTES - 1));
	assign sts.refused    = (eval_status != ST_OK);
	assign sts.is_erase   = (cmd_q == CMD_ERASE);
	assign sts.erase_done = (remaining_q == '0);
	assign sts.out_free   = !out_valid_q || rsp_ready;

	assign rsp_valid = out_valid_q;
	assign read_data = out_data_q;
	assign status    = out_status_q;
endmodule

[hw/rtl/nor_flash_array_model.sv]
// Top level of the NOR flash array model: controller plus datapath.
// Depends on nfa_pkg, nfa_intf, nfa_ctrl and nfa_dp.
//
// Usage: each word on cmd is one command (read byte, program byte, erase
// units); each gives exactly one word on rsp with read_data and status.
// The user must write the configuration registers through cfg_write_en /
// cfg_index / cfg_data only while no command is in flight (not enforced).
// After reset the cell array is swept to 0xFF, one byte a cycle, over all
// CAPACITY_BYTES addresses; cmd.ready stays low until the sweep ends.
// One command is worked on at a time, set by the controller sequence and
// the single write port of the cell array, in these states before IDLE:
//   read or program: CALC, EVAL, READ, MODIFY, then DONE
//   refused command: CALC, EVAL, then DONE
//   erase of N bytes: CALC, EVAL, one ERASE step per byte, then DONE
// The response sits in an output register; when rsp is stalled the next
// command is still accepted and worked on, and it waits at its last step
// until the register frees.
module nor_flash_array_model #(
	parameter int unsigned CAPACITY_BYTES = nfa_pkg::CAPACITY_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write_en,
	input  logic [nfa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [nfa_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	nfa_cmd_if.sink                            cmd,
	nfa_rsp_if.source                          rsp
);
	import nfa_pkg::*;

	dp_cmd_t    ctl;
	dp_status_t sts;
	logic       cmd_ready;
	logic       rsp_valid;
	logic [DATA_BITS-1:0]   read_data;
	logic [STATUS_BITS-1:0] status;

	nfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd.valid),
		.cmd_ready(cmd_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	nfa_dp #(
		.CAPACITY_BYTES(CAPACITY_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.command     (cmd.command),
		.byte_address(cmd.byte_address),
		.write_data  (cmd.write_data),
		.burst_start (cmd.burst_start),
		.erase_count (cmd.erase_count),
		.ctl         (ctl),
		.sts         (sts),
		.rsp_ready   (rsp.ready),
		.rsp_valid   (rsp_valid),
		.read_data   (read_data),
		.status      (status)
	);

	assign cmd.ready     = cmd_ready;
	assign rsp.valid     = rsp_valid;
	assign rsp.read_data = read_data;
	assign rsp.status    = status;
endmodule
